// ===== hdl/differential_drive_odometry_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the odometry core checker
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH

// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("odometry check failed");

// same-cycle implication
`define DDO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("odometry check failed");

`endif

// ===== hdl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and the arctangent table of the odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COUNT_BITS   = 16;

  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [19:0] DPT_RESET       = 20'd14641;
  localparam logic [31:0] APT_RESET       = 32'd2774527;

  // register byte addresses
  localparam logic [2:0] ADDR_DPT = 3'd0;
  localparam logic [2:0] ADDR_APT = 3'd4;

  // serial multiply step counts
  localparam logic [5:0] MUL1_LAST = 6'd31;
  localparam logic [5:0] P_STEPS   = 6'd20;
  localparam logic [5:0] MUL2_LAST = 6'd32;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_SETPOS = 2'd1,
    CMD_SNAP   = 2'd2,
    CMD_UNUSED = 2'd3
  } ddo_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_CSTART,
    ST_ROT,
    ST_MUL2,
    ST_DONE
  } ddo_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } ddo_cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [32:0] cos_v;
    logic signed [32:0] sin_v;
  } ddo_cordic_rsp_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_ba(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/ddo_if.sv =====
// ----------------------------------------------------------------------------
// ddo_in_if / ddo_out_if
// Valid/ready channels carrying commands in and pose results out.
// ----------------------------------------------------------------------------
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [15:0]        left_count;
  logic [15:0]        right_count;
  logic signed [31:0] set_x;
  logic signed [31:0] set_y;

  modport source (output valid, command, left_count, right_count, set_x, set_y,
                  input ready);
  modport sink   (input valid, command, left_count, right_count, set_x, set_y,
                  output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading_out;

  modport source (output valid, pos_x, pos_y, heading_out, input ready);
  modport sink   (input valid, pos_x, pos_y, heading_out, output ready);
endinterface

// ===== hdl/differential_drive_odometry_core.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Wheel-encoder odometry: serial multiplies and an iterative CORDIC.
// ----------------------------------------------------------------------------
// Channel    Dir  Contents
// sample_i   in   command, left_count, right_count, set_x, set_y
// result_o   out  pos_x, pos_y, heading_out
// APB        in   distance_per_tick @0x0, angle_per_tick_diff @0x4
//
// An encoder sample passes through acceptance, a bit-serial turn/distance
// multiply, a CORDIC start, the rotation, a bit-serial move scaling and a
// commit, which waits while a held result has not been taken.
// Set position and snap heading go through the commit state only; the first
// sample and unused commands finish on acceptance and give no result. One item is in work at a time.
// A stalled result holds in the output register; the next item is still taken.
// Reset clears the pose, the latch flag and the registers to their defaults.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddo_in_if.sink      sample_i,
  ddo_out_if.source   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ddo_pkg::*;

  ddo_state_e state_q, state_d;

  logic [19:0] dpt_q, dpt_d;
  logic [31:0] apt_q, apt_d;
  logic [31:0] x_q, x_d, y_q, y_d, hd_q, hd_d;
  logic [COUNT_BITS-1:0] ll_q, ll_d, lr_q, lr_d;
  logic        lat_q, lat_d;
  logic        mv_q, mv_d;
  logic [5:0]  cnt_q, cnt_d;

  // turn and distance serial multipliers
  logic signed [16:0] td_q, td_d, ps_q, ps_d;
  logic signed [17:0] th_q, th_d, ph_q, ph_d;
  logic [31:0]        tl_q, tl_d;
  logic [19:0]        pl_q, pl_d;

  // move scaling serial multipliers
  logic signed [38:0] xh_q, xh_d, yh_q, yh_d;
  logic [32:0]        xl_q, xl_d, yl_q, yl_d;

  // output register
  logic        ov_q, ov_d;
  logic [31:0] ox_q, ox_d, oy_q, oy_d, oh_q, oh_d;

  ddo_cordic_req_t creq;
  ddo_cordic_rsp_t crsp;

  logic signed [COUNT_BITS-1:0] dl, dr;
  logic signed [16:0] tpp, ppp;
  logic signed [18:0] tsum, psum;
  logic signed [37:0] pa;
  logic signed [39:0] xpp, ypp, xsum, ysum;
  logic [31:0] dx, dy;
  logic [32:0] snap_sum;
  logic        cfg_wr;

  ddo_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dpt_q   <= DPT_RESET;
      apt_q   <= APT_RESET;
      x_q     <= '0;
      y_q     <= '0;
      hd_q    <= '0;
      ll_q    <= '0;
      lr_q    <= '0;
      lat_q   <= 1'b0;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      dpt_q   <= dpt_d;
      apt_q   <= apt_d;
      x_q     <= x_d;
      y_q     <= y_d;
      hd_q    <= hd_d;
      ll_q    <= ll_d;
      lr_q    <= lr_d;
      lat_q   <= lat_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    td_q <= td_d;
    ps_q <= ps_d;
    th_q <= th_d;
    ph_q <= ph_d;
    tl_q <= tl_d;
    pl_q <= pl_d;
    xh_q <= xh_d;
    yh_q <= yh_d;
    xl_q <= xl_d;
    yl_q <= yl_d;
    ox_q <= ox_d;
    oy_q <= oy_d;
    oh_q <= oh_d;
  end

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr)
      ADDR_DPT: prdata = {12'd0, dpt_q};
      ADDR_APT: prdata = apt_q;
      default:  prdata = '0;
    endcase
  end

  // handshake outputs
  assign sample_i.ready     = (state_q == ST_IDLE);
  assign result_o.valid     = ov_q;
  assign result_o.pos_x     = ox_q;
  assign result_o.pos_y     = oy_q;
  assign result_o.heading_out = oh_q;

  // next state and datapath
  always_comb begin
    dl = COUNT_BITS'(sample_i.left_count - ll_q);
    dr = COUNT_BITS'(sample_i.right_count - lr_q);

    tpp  = tl_q[0] ? td_q : '0;
    tsum = 19'(th_q) + 19'(tpp);
    ppp  = pl_q[0] ? ps_q : '0;
    psum = 19'(ph_q) + 19'(ppp);

    pa   = $signed({ph_q, pl_q});
    xpp  = xl_q[0] ? 40'(pa) : '0;
    ypp  = yl_q[0] ? 40'(pa) : '0;
    if (cnt_q == MUL2_LAST) begin
      xsum = 40'(xh_q) - xpp;
      ysum = 40'(yh_q) - ypp;
    end else begin
      xsum = 40'(xh_q) + xpp;
      ysum = 40'(yh_q) + ypp;
    end

    // round half up to Q16.16
    dx = xh_q[37:6] + {31'd0, xh_q[5]};
    dy = yh_q[37:6] + {31'd0, yh_q[5]};

    snap_sum = {1'b0, hd_q} + 33'h01FFFFFFF;

    state_d = state_q;
    dpt_d = dpt_q;
    apt_d = apt_q;
    x_d   = x_q;
    y_d   = y_q;
    hd_d  = hd_q;
    ll_d  = ll_q;
    lr_d  = lr_q;
    lat_d = lat_q;
    mv_d  = mv_q;
    cnt_d = cnt_q;
    td_d  = td_q;
    ps_d  = ps_q;
    th_d  = th_q;
    ph_d  = ph_q;
    tl_d  = tl_q;
    pl_d  = pl_q;
    xh_d  = xh_q;
    yh_d  = yh_q;
    xl_d  = xl_q;
    yl_d  = yl_q;
    ov_d  = ov_q;
    ox_d  = ox_q;
    oy_d  = oy_q;
    oh_d  = oh_q;
    creq.start = 1'b0;
    creq.angle = hd_q + {th_q[0], tl_q[31:1]};

    if (cfg_wr && paddr == ADDR_DPT) dpt_d = pwdata[19:0];
    if (cfg_wr && paddr == ADDR_APT) apt_d = pwdata;

    if (ov_q && result_o.ready) ov_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          case (sample_i.command)
            CMD_SAMPLE: begin
              ll_d  = sample_i.left_count;
              lr_d  = sample_i.right_count;
              lat_d = 1'b1;
              if (lat_q) begin
                td_d  = 17'(dr) - 17'(dl);
                ps_d  = 17'(dr) + 17'(dl);
                th_d  = '0;
                ph_d  = '0;
                tl_d  = apt_q;
                pl_d  = dpt_q;
                cnt_d = '0;
                mv_d  = 1'b1;
                state_d = ST_MUL1;
              end
            end
            CMD_SETPOS: begin
              x_d  = sample_i.set_x;
              y_d  = sample_i.set_y;
              mv_d = 1'b0;
              state_d = ST_DONE;
            end
            CMD_SNAP: begin
              hd_d = {snap_sum[31:30], 30'd0};
              mv_d = 1'b0;
              state_d = ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_MUL1: begin
        // one multiplier bit a cycle, partial sum shifts right
        th_d = tsum[18:1];
        tl_d = {tsum[0], tl_q[31:1]};
        if (cnt_q < P_STEPS) begin
          ph_d = psum[18:1];
          pl_d = {psum[0], pl_q[19:1]};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == MUL1_LAST) state_d = ST_CSTART;
      end
      ST_CSTART: begin
        creq.start = 1'b1;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        if (crsp.done) begin
          xh_d  = '0;
          yh_d  = '0;
          xl_d  = crsp.cos_v;
          yl_d  = crsp.sin_v;
          cnt_d = '0;
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        // signed serial multiply, last bit carries negative weight
        xh_d = xsum[39:1];
        yh_d = ysum[39:1];
        xl_d = {xsum[0], xl_q[32:1]};
        yl_d = {ysum[0], yl_q[32:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == MUL2_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_q || result_o.ready) begin
          if (mv_q) begin
            x_d  = x_q + dx;
            y_d  = y_q + dy;
            hd_d = hd_q + tl_q;
          end
          ov_d = 1'b1;
          ox_d = x_d;
          oy_d = y_d;
          oh_d = hd_d;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative CORDIC rotator: one micro-rotation per cycle, quadrant folded.
// ----------------------------------------------------------------------------
module ddo_cordic (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ddo_pkg::ddo_cordic_req_t req_i,
  output ddo_pkg::ddo_cordic_rsp_t rsp_o
);
  import ddo_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [4:0]         step_q, step_d;
  logic [1:0]         quad_q, quad_d;
  logic signed [32:0] z_q, z_d;
  logic signed [32:0] vx_q, vx_d;
  logic signed [32:0] vy_q, vy_d;

  logic [32:0]        qsum;
  logic [1:0]         quad_n;
  logic [31:0]        resid;
  logic signed [32:0] sx, sy, at;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    z_q    <= z_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
  end

  always_comb begin
    qsum   = {1'b0, req_i.angle} + 33'h020000000;
    quad_n = qsum[31:30];
    resid  = req_i.angle - {quad_n, 30'd0};
    sx     = vx_q >>> step_q;
    sy     = vy_q >>> step_q;
    at     = $signed({1'b0, atan_ba(step_q)});

    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quad_d = quad_q;
    z_d    = z_q;
    vx_d   = vx_q;
    vy_d   = vy_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quad_d = quad_n;
      z_d    = 33'($signed(resid));
      vx_d   = $signed({1'b0, CORDIC_GAIN_Q30});
      vy_d   = '0;
    end else if (busy_q) begin
      // rotate towards zero residual angle
      if (!z_q[32]) begin
        vx_d = vx_q - sy;
        vy_d = vy_q + sx;
        z_d  = z_q - at;
      end else begin
        vx_d = vx_q + sy;
        vy_d = vy_q - sx;
        z_d  = z_q + at;
      end
      step_d = step_q + 5'd1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // unfold the quadrant
  always_comb begin
    rsp_o.done = done_q;
    case (quad_q)
      2'd0: begin
        rsp_o.cos_v = vx_q;
        rsp_o.sin_v = vy_q;
      end
      2'd1: begin
        rsp_o.cos_v = -vy_q;
        rsp_o.sin_v = vx_q;
      end
      2'd2: begin
        rsp_o.cos_v = -vx_q;
        rsp_o.sin_v = -vy_q;
      end
      default: begin
        rsp_o.cos_v = vy_q;
        rsp_o.sin_v = -vx_q;
      end
    endcase
  end

endmodule

// ===== hdl/ddo_checker.sv =====
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry core, bound to the top level.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_core_assert.svh"

module ddo_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_ready
);
  import ddo_pkg::*;

  // a waiting result is not withdrawn
  `DDO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // an unused command leaves the block free for the next transaction
  `DDO_ASSERT_NEXT(a_unused_idle, in_valid && in_ready && in_command == CMD_UNUSED, in_ready)

  // set position goes busy for its commit cycle
  `DDO_ASSERT_NEXT(a_setpos_busy, in_valid && in_ready && in_command == CMD_SETPOS,
                   !in_ready)

  // snap heading goes busy for its commit cycle
  `DDO_ASSERT_NEXT(a_snap_busy, in_valid && in_ready && in_command == CMD_SNAP,
                   !in_ready)

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (sample_i.valid),
  .in_ready   (sample_i.ready),
  .in_command (sample_i.command),
  .out_valid  (result_o.valid),
  .out_ready  (result_o.ready)
);

// ===== tb/tb_differential_drive_odometry_core.sv =====
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry_core
// Self-checking bench for the wheel odometry core: a bit-exact pose predictor
// in a scoreboard class, random valid/ready idling on both channels and APB
// register phases covering the default, extreme and random settings.
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry_core;
  import ddo_pkg::*;

  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         DRAIN_CYCLES = 120;

  typedef struct {
    logic [1:0]         command;
    logic [15:0]        left_count;
    logic [15:0]        right_count;
    logic signed [31:0] set_x;
    logic signed [31:0] set_y;
  } cmd_item_t;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
  } pose_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          cycles = 0;
  bit          quiet_tail = 1'b0;
  logic [15:0] enc_l = '0;
  logic [15:0] enc_r = '0;

  ddo_in_if  in_if ();
  ddo_out_if out_if ();

  differential_drive_odometry_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (in_if),
    .result_o (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Pose predictor and queue of expected poses
  class pose_scoreboard;
    logic [31:0] x, y, hdg, apt;
    logic [19:0] dpt;
    logic [15:0] last_l, last_r;
    bit          latched;
    pose_t       pending[$];
    int          errors;
    longint      atan_tab[16] = '{536870912, 316933406, 167458907, 85004756,
                                  42667331, 21354465, 10679838, 5340245, 2670163,
                                  1335087, 667544, 333772, 166886, 83443, 41722,
                                  20861};

    function new();
      x = '0; y = '0; hdg = '0; last_l = '0; last_r = '0; latched = 1'b0;
      dpt = DPT_RESET; apt = APT_RESET; errors = 0;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %h expected %h", what, got, want);
    endtask

    function longint wheel_delta(input logic [15:0] prev, input logic [15:0] cur);
      logic [15:0] d;
      d = cur - prev;
      return longint'($signed(d));
    endfunction

    // quadrant-reduced rotation, Q1.30 cosine and sine
    function void rotate(input logic [31:0] ang, output longint c, output longint s);
      logic [32:0] qs;
      logic [1:0]  q;
      logic [31:0] r;
      longint      z, vx, vy, sx, sy;
      qs = {1'b0, ang} + 33'h020000000;
      q  = qs[31:30];
      r  = ang - {q, 30'b0};
      z  = longint'($signed(r));
      vx = longint'(CORDIC_GAIN_Q30);
      vy = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (z >= 0) begin
          vx -= sy; vy += sx; z -= atan_tab[i];
        end else begin
          vx += sy; vy -= sx; z += atan_tab[i];
        end
      end
      case (q)
        2'd0: begin c = vx;  s = vy;  end
        2'd1: begin c = -vy; s = vx;  end
        2'd2: begin c = -vx; s = -vy; end
        default: begin c = vy; s = -vx; end
      endcase
    endfunction

    // round half up from meters*2^25 times Q1.30 to Q16.16
    function logic [31:0] scale_move(input longint p, input longint t);
      logic signed [127:0] a, b, m;
      a = p;
      b = t;
      m = a * b + (128'sd1 <<< 38);
      return m[70:39];
    endfunction

    function void note_input(input cmd_item_t it);
      longint      dl, dr, p, c, s;
      logic [63:0] turn;
      logic [33:0] snap_sum;
      if (it.command == CMD_SAMPLE) begin
        if (!latched) begin
          latched = 1'b1; last_l = it.left_count; last_r = it.right_count;
          return;
        end
        dl = wheel_delta(last_l, it.left_count);
        dr = wheel_delta(last_r, it.right_count);
        last_l = it.left_count; last_r = it.right_count;
        turn = 64'(dr - dl) * {32'b0, apt};
        p = (dl + dr) * longint'({12'b0, dpt});
        rotate(hdg + turn[32:1], c, s);
        x += scale_move(p, c);
        y += scale_move(p, s);
        hdg += turn[31:0];
      end else if (it.command == CMD_SETPOS) begin
        x = it.set_x; y = it.set_y;
      end else if (it.command == CMD_SNAP) begin
        snap_sum = {2'b0, hdg} + 34'h01FFFFFFF;
        hdg = {snap_sum[31:30], 30'b0};
      end else begin
        return;
      end
      pending.push_back('{x, y, hdg});
    endfunction

    task check_result(input logic [31:0] px, input logic [31:0] py, input logic [31:0] ph);
      pose_t e;
      if (pending.size() == 0) begin
        report("unexpected result pos_x", px, 'x);
        return;
      end
      e = pending.pop_front();
      if (px !== e.pos_x) report("pos_x", px, e.pos_x);
      if (py !== e.pos_y) report("pos_y", py, e.pos_y);
      if (ph !== e.heading) report("heading_out", ph, e.heading);
    endtask
  endclass

  pose_scoreboard sb = new();

  // Clock, timeout
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.command = CMD_SAMPLE;
    in_if.left_count = '0;
    in_if.right_count = '0;
    in_if.set_x = '0;
    in_if.set_y = '0;
    out_if.ready = 1'b0;
  end

  // Result sink with random stall bursts
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.pos_x, out_if.pos_y, out_if.heading_out);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= rst_ni;
      end
    end
  end

  // One APB write: setup then access
  task apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_DPT) sb.dpt = data[19:0];
    else sb.apt = data;
  endtask

  // Wait for all expected poses, then let the core settle
  task wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task configure(input logic [19:0] dpt, input logic [31:0] apt);
    in_if.valid <= 1'b0;
    wait_idle();
    apb_write(ADDR_DPT, {12'b0, dpt});
    apb_write(ADDR_APT, apt);
  endtask

  // Send one transaction, with an optional random gap beforehand
  task send_cmd(input logic [1:0] cmd, input logic [15:0] l, input logic [15:0] r,
                input logic [31:0] sx, input logic [31:0] sy);
    cmd_item_t it;
    int gap;
    it = '{cmd, l, r, sx, sy};
    gap = (!quiet_tail && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.left_count <= l;
    in_if.right_count <= r;
    in_if.set_x <= sx;
    in_if.set_y <= sy;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
  endtask

  task sample(input logic [15:0] l, input logic [15:0] r);
    enc_l = l; enc_r = r;
    send_cmd(CMD_SAMPLE, l, r, $urandom(), $urandom());
  endtask

  task random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70)
      sample(enc_l + 16'($urandom_range(0, 400) - 200),
             enc_r + 16'($urandom_range(0, 400) - 200));
    else if (sel < 78) sample(16'($urandom()), 16'($urandom()));
    else if (sel < 86)
      send_cmd(CMD_SETPOS, 16'($urandom()), 16'($urandom()), $urandom(), $urandom());
    else if (sel < 96)
      send_cmd(CMD_SNAP, 16'($urandom()), 16'($urandom()), $urandom(), $urandom());
    else
      send_cmd(CMD_UNUSED, 16'($urandom()), 16'($urandom()), $urandom(), $urandom());
  endtask

  // Main sequence
  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first sample latch, unused command, position extremes, moves
    sample(16'd100, 16'd100);
    send_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    sample(16'd110, 16'd120);
    send_cmd(CMD_SETPOS, '0, '0, 32'h7FFFFFFF, 32'h80000000);
    sample(16'd90, 16'd150);
    send_cmd(CMD_SETPOS, '0, '0, 32'h80000000, 32'h7FFFFFFF);
    sample(16'hFFF0, 16'h0010);
    send_cmd(CMD_SNAP, '0, '0, '0, '0);
    send_cmd(CMD_SETPOS, '0, '0, '0, '0);
    sample(16'h7FF0, 16'h8010);

    // halfway and seven-eighths snap cases with an eighth turn per tick
    configure(20'hFFFFF, 32'h20000000);
    sample(enc_l, enc_r + 16'd1);
    send_cmd(CMD_SNAP, '0, '0, '0, '0);
    sample(enc_l, enc_r + 16'd7);
    send_cmd(CMD_SNAP, '0, '0, '0, '0);
    // largest wheel travel in both directions: position wraps
    sample(enc_l + 16'h7FFF, enc_r + 16'h7FFF);
    sample(enc_l + 16'h8000, enc_r + 16'h8000);
    sample(enc_l + 16'h7FFF, enc_r + 16'h8000);

    // random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(DPT_RESET, APT_RESET);
        1: configure(20'd0, 32'hFFFFFFFF);
        2: configure(20'hFFFFF, 32'd0);
        3: configure(20'($urandom()), $urandom());
        4: configure(20'($urandom()), $urandom_range(0, 32'h00400000));
        default: configure(DPT_RESET, APT_RESET);
      endcase
      if (ph == 5) quiet_tail = 1'b1;
      repeat (230) random_item();
    end
    in_if.valid <= 1'b0;

    wait_idle();
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== differential_drive_odometry_core.f =====
+incdir+hdl
hdl/ddo_pkg.sv
hdl/ddo_if.sv
hdl/ddo_cordic.sv
hdl/differential_drive_odometry_core.sv
hdl/ddo_checker.sv
tb/tb_differential_drive_odometry_core.sv
